// ===== hdl/sbrd_pkg.sv =====
// shared types and constants for the serial bit-rate divider resolver
// no dependencies; imported by every module of the block
`default_nettype none

package sbrd_pkg;

    // operand and quotient widths
    localparam int QUOT_W         = 32;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

    // result field widths
    localparam int SEL_W  = 2;
    localparam int DIVV_W = 8;

    // prescaler search: q_n = quotient >> (BASE_SHIFT + STEP_SHIFT * n)
    localparam int NUM_PRESCALE = 4;
    localparam int BASE_SHIFT   = 2;
    localparam int STEP_SHIFT   = 2;

    // largest q for which q - 1 still fits the divider
    localparam logic [QUOT_W-1:0] Q_LIMIT = QUOT_W'(256);

    localparam logic [SEL_W-1:0]  PRESCALE_MAX = 2'd3;
    localparam logic [DIVV_W-1:0] DIVIDER_MAX  = 8'd255;

    // payload carried down the divider pipeline
    typedef struct packed {
        logic [QUOT_W-1:0] rem;
        logic [QUOT_W-1:0] dvd;
        logic [QUOT_W-1:0] dsr;
    } sbrd_div_t;

endpackage : sbrd_pkg

`default_nettype wire

// ===== hdl/spi_bit_rate_divider_resolve.sv =====
// start passes through 16 divider stages, then 1 select stage, before it reaches done
// throughput: one item per cycle; the divider pipeline, 2 quotient bits a stage, sets it
// busy stays low, and done is a single-cycle strobe the receiver cannot hold off
// reset: rst_n clears all valid bits asynchronously; items in flight are dropped
// top level of the serial bit-rate divider resolver; depends on sbrd_pkg,
// sbrd_divider and sbrd_select
`default_nettype none

module spi_bit_rate_divider_resolve
    import sbrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [QUOT_W-1:0] rate_hz,
    input  wire logic [QUOT_W-1:0] source_clock_hz,
    output logic                   done,
    output logic [SEL_W-1:0]       prescale_select,
    output logic [DIVV_W-1:0]      divider_value
);

    // floor(clk / (4 * 4^n * rate)) equals floor(clk / rate) shifted right by
    // 2 + 2n, so one full-width quotient serves all four prescaler trials.
    // a zero rate makes the divider return all ones, which saturates naturally.

    logic              accept;
    logic              quot_valid;
    logic [QUOT_W-1:0] quot;

    // the pipeline never stalls, so an item is taken whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // clock / rate, one item entering each cycle
    sbrd_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .dividend  (source_clock_hz),
        .divisor   (rate_hz),
        .valid_out (quot_valid),
        .quotient  (quot)
    );

    // pick the lowest prescaler whose divider fits, else saturate
    sbrd_select u_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid_in        (quot_valid),
        .quotient        (quot),
        .done            (done),
        .prescale_select (prescale_select),
        .divider_value   (divider_value)
    );

endmodule : spi_bit_rate_divider_resolve

`default_nettype wire

// ===== hdl/sbrd_div_stage.sv =====
// one register stage of the restoring divider, two quotient bits per stage
// depends on sbrd_pkg
`default_nettype none

module sbrd_div_stage
    import sbrd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      valid_in,
    input  wire sbrd_div_t data_in,
    output logic           valid_out,
    output sbrd_div_t      data_out
);

    logic      valid_reg;
    sbrd_div_t data_reg;
    sbrd_div_t data_next;

    always_comb
    begin
        logic [QUOT_W-1:0] rem_v;
        logic [QUOT_W-1:0] dvd_v;
        logic [QUOT_W:0]   trial;
        logic [QUOT_W+1:0] diff;
        rem_v = data_in.rem;
        dvd_v = data_in.dvd;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial = {rem_v, dvd_v[QUOT_W-1]};
            diff  = {1'b0, trial} - {2'b00, data_in.dsr};
            if (!diff[QUOT_W+1])
            begin
                rem_v = diff[QUOT_W-1:0];
                dvd_v = {dvd_v[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_v = trial[QUOT_W-1:0];
                dvd_v = {dvd_v[QUOT_W-2:0], 1'b0};
            end
        end
        data_next.rem = rem_v;
        data_next.dvd = dvd_v;
        data_next.dsr = data_in.dsr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule : sbrd_div_stage

`default_nettype wire

// ===== hdl/sbrd_divider.sv =====
// pipelined unsigned divider, clock over rate, one item per cycle
// depends on sbrd_pkg and sbrd_div_stage
`default_nettype none

module sbrd_divider
    import sbrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  wire logic [QUOT_W-1:0] dividend,
    input  wire logic [QUOT_W-1:0] divisor,
    output logic                   valid_out,
    output logic [QUOT_W-1:0]      quotient
);

    logic      stage_valid [DIV_STAGES+1];
    sbrd_div_t stage_data  [DIV_STAGES+1];

    assign stage_valid[0]    = valid_in;
    assign stage_data[0].rem = '0;
    assign stage_data[0].dvd = dividend;
    assign stage_data[0].dsr = divisor;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        sbrd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[s]),
            .data_in   (stage_data[s]),
            .valid_out (stage_valid[s+1]),
            .data_out  (stage_data[s+1])
        );
    end

    assign valid_out = stage_valid[DIV_STAGES];
    assign quotient  = stage_data[DIV_STAGES].dvd;

    // an item leaving the divider entered at its input and passed all DIV_STAGES register stages
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> $past(valid_in, DIV_STAGES))
        else $error("divider output without a matching input item");

endmodule : sbrd_divider

`default_nettype wire

// ===== hdl/sbrd_select.sv =====
// prescaler search over the quotient and registered result stage
// depends on sbrd_pkg
`default_nettype none

module sbrd_select
    import sbrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  wire logic [QUOT_W-1:0] quotient,
    output logic                   done,
    output logic [SEL_W-1:0]       prescale_select,
    output logic [DIVV_W-1:0]      divider_value
);

    logic              done_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [SEL_W-1:0]  sel_next;
    logic [DIVV_W-1:0] div_reg;
    logic [DIVV_W-1:0] div_next;

    // q shrinks as n grows, so the lowest fitting n wins; scan down, last hit stays
    always_comb
    begin
        logic [QUOT_W-1:0] qn;
        logic [QUOT_W-1:0] qm1;
        sel_next = PRESCALE_MAX;
        div_next = DIVIDER_MAX;
        for (int n = NUM_PRESCALE - 1; n >= 0; n--)
        begin
            qn  = quotient >> (BASE_SHIFT + STEP_SHIFT * n);
            qm1 = qn - QUOT_W'(1);
            if (qn <= Q_LIMIT)
            begin
                sel_next = SEL_W'(n);
                div_next = (qn == '0) ? '0 : qm1[DIVV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        div_reg <= div_next;
    end

    assign done            = done_reg;
    assign prescale_select = sel_reg;
    assign divider_value   = div_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |=> done)
        else $error("quotient item did not produce a result");

    // a higher prescaler is used only when the lower one overflowed,
    // so its divider is at least 63, just under a quarter of the range
    a_min_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (done && prescale_select != '0) |-> (divider_value >= 8'd63))
        else $error("prescaler raised while a lower one would fit");

endmodule : sbrd_select

`default_nettype wire
